// ----- hw/rtl/preemptive_priority_scheduler_assert.svh -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler assertion macros
// Shared assertion forms for the checker of the scheduler.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, switched off during reset.
`define PPS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pps check failed");

// Next-cycle implication, switched off during reset.
`define PPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pps check failed");

// Next-cycle implication that also holds across reset.
`define PPS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pps check failed");

`endif

// ----- hw/rtl/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared types, codes and constants of the scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int MAX_TASKS_DEFAULT = 16;
   localparam int TIME_W            = 16;
   localparam int PRIO_W            = 8;
   localparam int SLOT_W            = 4;
   localparam int COUNT_W           = 5;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

   // request function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // one table row as stored in the task memory
   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] remaining;
      logic [PRIO_W-1:0] prio;
   } task_entry_type;

   // control from the sequencer to the selection unit
   typedef struct packed {
      logic clear;
      logic valid;
      logic active;
   } select_ctl_type;

endpackage

// ----- hw/rtl/pps_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/pps_select.sv -----
// ----------------------------------------------------------------------------
// Scheduler selection unit
// Compares one table row a cycle and keeps the best ready task so far.
// ----------------------------------------------------------------------------
module pps_select
   import pps_pkg::*;
#(
   parameter int AW = 4
) (
   input  logic                clock,
   input  select_ctl_type      ctl,
   input  logic [AW-1:0]       idx,
   input  task_entry_type      entry,
   input  logic [TIME_W-1:0]   now,
   output logic                found,
   output logic [AW-1:0]       pick,
   output task_entry_type      pick_entry
);

   logic           found_ff, found_in;
   logic [AW-1:0]  pick_ff, pick_in;
   task_entry_type entry_ff, entry_in;
   logic           take;

   // strict compare keeps the lowest index on a tie
   assign take = ctl.valid && ctl.active && (entry.arrival <= now) &&
                 (!found_ff || (entry.prio > entry_ff.prio));

   always_comb begin
      found_in = found_ff;
      pick_in  = pick_ff;
      entry_in = entry_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         pick_in  = idx;
         entry_in = entry;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      pick_ff  <= pick_in;
      entry_ff <= entry_in;
   end

   assign found      = found_ff;
   assign pick       = pick_ff;
   assign pick_entry = entry_ff;

endmodule

// ----- hw/rtl/preemptive_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Task table with a sequential scan for the highest-priority ready task.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: func selects load or tick. A load writes
//   one table slot and marks it active and gives no response. A tick scans
//   the slots below the effective count, one slot a cycle through the task
//   memory read port, runs the winner for one time unit and returns one
//   rsp_* transaction. A tick passes through the scan, drain, update and
//   result states, skipping scan and drain at a count of zero; req_stall
//   stays high for the whole tick, from acceptance until the result enters
//   the output register, so no new request is taken while a tick is busy.
//   csr_wr_en writes process_count; write it only while the block is idle.
//   Reset clears the active flags, the time counter and the output register
//   and sets process_count to 1; the table contents are undefined until
//   loaded. A stalled response is held in the output register while the
//   next request is taken; the next tick result waits until it drains.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
   import pps_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [SLOT_W-1:0]  req_slot,
   input  logic [TIME_W-1:0]  req_arrival,
   input  logic [TIME_W-1:0]  req_burst,
   input  logic [PRIO_W-1:0]  req_priority_req,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SLOT_W-1:0]  rsp_running_slot,
   output logic               rsp_idle,
   output logic               rsp_finished,
   output logic [TIME_W-1:0]  rsp_turnaround,
   output logic [TIME_W-1:0]  rsp_waiting,
   output logic [TIME_W-1:0]  rsp_tick_time,
   output logic               rsp_all_done,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   localparam int AW  = $clog2(MAX_TASKS);
   localparam int EW  = ($clog2(MAX_TASKS + 1) > COUNT_W) ? $clog2(MAX_TASKS + 1) : COUNT_W;
   localparam int SW  = (AW > SLOT_W) ? AW : SLOT_W;
   localparam int SLW = SW + 1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DRAIN  = 5'b00100,
      S_UPDATE = 5'b01000,
      S_RESULT = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] pcount_ff, pcount_in;
   logic [EW-1:0]      count_ff, count_in;
   logic [AW-1:0]      iss_ff, iss_in;
   logic [AW-1:0]      rd_idx_ff;
   logic               rd_pend_ff;
   logic [MAX_TASKS-1:0] active_ff, active_in;
   logic [TIME_W-1:0]  time_ff, time_in;

   // result holding between update and output
   logic               res_idle_ff, res_idle_in;
   logic               res_fin_ff, res_fin_in;
   logic [TIME_W-1:0]  res_tat_ff, res_tat_in;
   logic [TIME_W-1:0]  res_wait_ff, res_wait_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic               out_idle_ff, out_idle_in;
   logic               out_fin_ff, out_fin_in;
   logic [TIME_W-1:0]  out_tat_ff, out_tat_in;
   logic [TIME_W-1:0]  out_wait_ff, out_wait_in;
   logic [TIME_W-1:0]  out_time_ff, out_time_in;
   logic               out_done_ff, out_done_in;

   logic               accept;
   logic [SLW-1:0]     slot_wide;
   logic [EW-1:0]      eff_count;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   task_entry_type     ram_wdata;
   task_entry_type     ram_rdata;
   task_entry_type     load_entry;
   task_entry_type     upd_entry;
   select_ctl_type     sel_ctl;
   logic               sel_found;
   logic [AW-1:0]      sel_pick;
   task_entry_type     sel_entry;
   logic [TIME_W-1:0]  time_next;
   logic [TIME_W-1:0]  rem_next;
   logic [TIME_W-1:0]  tat;
   logic               any_active;
   logic               out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign slot_wide = SLW'(req_slot);
   assign eff_count = (EW'(pcount_ff) > EW'(MAX_TASKS)) ? EW'(MAX_TASKS) : EW'(pcount_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign load_entry.arrival   = req_arrival;
   assign load_entry.burst     = req_burst;
   assign load_entry.remaining = req_burst;
   assign load_entry.prio      = req_priority_req;

   // saturate the time counter
   assign time_next = (time_ff == TIME_MAX) ? time_ff : time_ff + TIME_W'(1);
   assign rem_next  = (sel_entry.remaining != '0) ? sel_entry.remaining - TIME_W'(1) : '0;
   assign tat       = time_next - sel_entry.arrival;

   always_comb begin
      upd_entry           = sel_entry;
      upd_entry.remaining = rem_next;
   end

   always_comb begin
      any_active = 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (active_ff[i] && (EW'(i) < count_ff)) begin
            any_active = 1'b1;
         end
      end
   end

   assign sel_ctl.clear  = accept;
   assign sel_ctl.valid  = rd_pend_ff;
   assign sel_ctl.active = active_ff[rd_idx_ff];

   always_comb begin
      state_in    = state_ff;
      pcount_in   = pcount_ff;
      count_in    = count_ff;
      iss_in      = iss_ff;
      active_in   = active_ff;
      time_in     = time_ff;
      res_idle_in = res_idle_ff;
      res_fin_in  = res_fin_ff;
      res_tat_in  = res_tat_ff;
      res_wait_in = res_wait_ff;
      ram_we      = 1'b0;
      ram_waddr   = slot_wide[AW-1:0];
      ram_wdata   = load_entry;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_slot_in  = out_slot_ff;
      out_idle_in  = out_idle_ff;
      out_fin_in   = out_fin_ff;
      out_tat_in   = out_tat_ff;
      out_wait_in  = out_wait_ff;
      out_time_in  = out_time_ff;
      out_done_in  = out_done_ff;

      if (csr_wr_en) begin
         pcount_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_LOAD) begin
                  // drop loads beyond the table
                  if (slot_wide < SLW'(MAX_TASKS)) begin
                     ram_we                        = 1'b1;
                     active_in[slot_wide[AW-1:0]]  = 1'b1;
                  end
               end else begin
                  count_in = eff_count;
                  iss_in   = '0;
                  state_in = (eff_count == '0) ? S_UPDATE : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            iss_in = iss_ff + AW'(1);
            if (EW'(iss_ff) == count_ff - EW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            time_in     = time_next;
            res_idle_in = !sel_found;
            res_fin_in  = 1'b0;
            res_tat_in  = '0;
            res_wait_in = '0;
            if (sel_found) begin
               ram_we    = 1'b1;
               ram_waddr = sel_pick;
               ram_wdata = upd_entry;
               if (rem_next == '0) begin
                  active_in[sel_pick] = 1'b0;
                  res_fin_in          = 1'b1;
                  res_tat_in          = tat;
                  res_wait_in         = (tat >= sel_entry.burst) ? tat - sel_entry.burst : '0;
               end
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            // hold until the output register drains
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_slot_in  = res_idle_ff ? '0 : SLOT_W'(sel_pick);
               out_idle_in  = res_idle_ff;
               out_fin_in   = res_fin_ff;
               out_tat_in   = res_tat_ff;
               out_wait_in  = res_wait_ff;
               out_time_in  = time_ff;
               out_done_in  = !any_active;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pcount_ff    <= COUNT_RESET;
         active_ff    <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcount_ff    <= pcount_in;
         active_ff    <= active_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= (state_ff == S_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      iss_ff      <= iss_in;
      rd_idx_ff   <= iss_ff;
      res_idle_ff <= res_idle_in;
      res_fin_ff  <= res_fin_in;
      res_tat_ff  <= res_tat_in;
      res_wait_ff <= res_wait_in;
      out_slot_ff <= out_slot_in;
      out_idle_ff <= out_idle_in;
      out_fin_ff  <= out_fin_in;
      out_tat_ff  <= out_tat_in;
      out_wait_ff <= out_wait_in;
      out_time_ff <= out_time_in;
      out_done_ff <= out_done_in;
   end

   pps_ram #(
      .WIDTH ($bits(task_entry_type)),
      .DEPTH (MAX_TASKS)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (iss_ff),
      .rd_data (ram_rdata)
   );

   pps_select #(
      .AW (AW)
   ) u_select (
      .clock      (clock),
      .ctl        (sel_ctl),
      .idx        (rd_idx_ff),
      .entry      (ram_rdata),
      .now        (time_ff),
      .found      (sel_found),
      .pick       (sel_pick),
      .pick_entry (sel_entry)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_slot = out_slot_ff;
   assign rsp_idle         = out_idle_ff;
   assign rsp_finished     = out_fin_ff;
   assign rsp_turnaround   = out_tat_ff;
   assign rsp_waiting      = out_wait_ff;
   assign rsp_tick_time    = out_time_ff;
   assign rsp_all_done     = out_done_ff;

endmodule

// ----- hw/rtl/pps_checker.sv -----
// ----------------------------------------------------------------------------
// Preemptive priority scheduler checker
// Port-level checks of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "preemptive_priority_scheduler_assert.svh"

module pps_checker
   import pps_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_func,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [SLOT_W-1:0]  rsp_running_slot,
   input logic               rsp_idle,
   input logic               rsp_finished,
   input logic [TIME_W-1:0]  rsp_turnaround,
   input logic [TIME_W-1:0]  rsp_waiting,
   input logic [TIME_W-1:0]  rsp_tick_time
);

   // reset empties the output register
   `PPS_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // an accepted tick keeps the block busy while it scans
   `PPS_ASSERT_NEXT(a_tick_busy, clock, reset,
      req_valid && !req_stall && (req_func == FUNC_TICK), req_stall)

   // an idle tick runs nothing and finishes nothing
   `PPS_ASSERT_SAME(a_idle_quiet, clock, reset, rsp_valid && rsp_idle,
      !rsp_finished && (rsp_running_slot == '0) && (rsp_turnaround == '0))

   // waiting time never exceeds turnaround
   `PPS_ASSERT_SAME(a_wait_bound, clock, reset, rsp_valid && rsp_finished,
      rsp_waiting <= rsp_turnaround)

   // a stalled response transaction is held
   `PPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_tick_time) && $stable(rsp_running_slot))

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
